[hw/rtl/windowed_sine_tone_generator_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the windowed sine tone generator
// Implication checks on clk, switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_SINE_TONE_GENERATOR_CORE_MACROS_SVH
`define WINDOWED_SINE_TONE_GENERATOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSTG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WSTG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/wstg_pkg.sv]
// ----------------------------------------------------------------------------
// wstg_pkg
// Shared types and constants of the windowed sine tone generator.
// ----------------------------------------------------------------------------
package wstg_pkg;

  localparam int DEF_INDEX_BITS  = 24;
  localparam int DEF_PHASE_BITS  = 32;
  localparam int DEF_TABLE_BITS  = 12;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int AMP_BITS = 16;
  localparam int AMP_FRAC = 15;
  localparam int REG_IDX_BITS = 3;

  localparam logic [63:0] FREQ_WORD_RESET = 64'd89478485;
  localparam logic [AMP_BITS-1:0] AMPLITUDE_RESET = 16'd16384;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_FREQ_WORD    = 3'd0,
    REG_PHASE_OFFSET = 3'd1,
    REG_AMPLITUDE    = 3'd2,
    REG_START_INDEX  = 3'd3,
    REG_END_INDEX    = 3'd4
  } wstg_reg_t;

  // Control travelling alongside each sample through the pipe.
  typedef struct packed {
    logic valid;
    logic win;
    logic neg;
  } wstg_ctl_t;

endpackage

[hw/rtl/windowed_sine_tone_generator_core.sv]
// ----------------------------------------------------------------------------
// windowed_sine_tone_generator_core
// Direct digital synthesis tone source with amplitude and sample window.
// ----------------------------------------------------------------------------
// A request (start with sample_index) is taken on any cycle in which busy is
// low; busy is only high during reset, so one sample index can enter every
// clock. Each request yields exactly one result, shown for a single cycle with
// done high; the five register stages are multiply, phase add and quadrant
// fold, quarter-wave table read, gain multiply, and clamp/sign into the
// output registers. The receiver cannot hold results off, so it must take
// every done cycle. Indexes outside
// [start_index, end_index) give sample_value 0 and in_window 0. Write the
// configuration registers only while no request is in flight.
// ----------------------------------------------------------------------------
module windowed_sine_tone_generator_core #(
  parameter int INDEX_BITS  = wstg_pkg::DEF_INDEX_BITS,
  parameter int PHASE_BITS  = wstg_pkg::DEF_PHASE_BITS,
  parameter int TABLE_BITS  = wstg_pkg::DEF_TABLE_BITS,
  parameter int SAMPLE_BITS = wstg_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [INDEX_BITS-1:0]                  sample_index,
  output logic                                   done,
  output logic signed [SAMPLE_BITS-1:0]          sample_value,
  output logic                                   in_window,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [wstg_pkg::REG_IDX_BITS-1:0]      cfg_index,
  input  logic [((PHASE_BITS > INDEX_BITS) ? PHASE_BITS : INDEX_BITS + 1)-1:0] cfg_data
);
  import wstg_pkg::*;

  `include "windowed_sine_tone_generator_core_macros.svh"

  localparam int DATA_BITS = (PHASE_BITS > INDEX_BITS) ? PHASE_BITS : INDEX_BITS + 1;
  localparam int LATENCY   = 5;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                  accept;
  logic [PHASE_BITS-1:0] freq_word;
  logic [PHASE_BITS-1:0] phase_offset;
  logic [AMP_BITS-1:0]   amplitude;
  logic [INDEX_BITS:0]   start_index;
  logic [INDEX_BITS:0]   end_index;
  wstg_ctl_t             ctl_b;
  wstg_ctl_t             ctl_c;
  logic [TABLE_BITS-2:0] rom_addr;
  logic [SAMPLE_BITS-2:0] mag;

  assign busy   = rst;
  assign accept = start & ~busy;

  wstg_cfg_regs #(
    .INDEX_BITS (INDEX_BITS),
    .PHASE_BITS (PHASE_BITS),
    .DATA_BITS  (DATA_BITS)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .freq_word    (freq_word),
    .phase_offset (phase_offset),
    .amplitude    (amplitude),
    .start_index  (start_index),
    .end_index    (end_index)
  );

  wstg_phase #(
    .INDEX_BITS (INDEX_BITS),
    .PHASE_BITS (PHASE_BITS),
    .TABLE_BITS (TABLE_BITS)
  ) u_phase (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .sample_index (sample_index),
    .freq_word    (freq_word),
    .phase_offset (phase_offset),
    .start_index  (start_index),
    .end_index    (end_index),
    .ctl_out      (ctl_b),
    .rom_addr     (rom_addr)
  );

  wstg_sine_rom #(
    .TABLE_BITS  (TABLE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_rom (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (ctl_b),
    .rom_addr (rom_addr),
    .ctl_out  (ctl_c),
    .mag      (mag)
  );

  wstg_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk          (clk),
    .rst          (rst),
    .ctl_in       (ctl_c),
    .mag          (mag),
    .amplitude    (amplitude),
    .done         (done),
    .sample_value (sample_value),
    .in_window    (in_window)
  );

  `WSTG_ASSERT_SAME(a_latency, 1'b1, done == $past(accept, LATENCY), "result does not follow request")
  `WSTG_ASSERT_SAME(a_outside_zero, done && !in_window, sample_value == '0, "nonzero sample outside window")
  `WSTG_ASSERT_SAME(a_no_min, done, sample_value != SAMPLE_MIN, "sample beyond symmetric range")
  `WSTG_ASSERT_SAME(a_win_with_done, in_window, done, "in_window without result")

endmodule

[hw/rtl/wstg_cfg_regs.sv]
// ----------------------------------------------------------------------------
// wstg_cfg_regs
// Configuration register file: phase increment, phase offset, gain and window.
// ----------------------------------------------------------------------------
module wstg_cfg_regs #(
  parameter int INDEX_BITS = wstg_pkg::DEF_INDEX_BITS,
  parameter int PHASE_BITS = wstg_pkg::DEF_PHASE_BITS,
  parameter int DATA_BITS  = wstg_pkg::DEF_PHASE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wstg_pkg::REG_IDX_BITS-1:0] cfg_index,
  input  logic [DATA_BITS-1:0]              cfg_data,
  output logic [PHASE_BITS-1:0]             freq_word,
  output logic [PHASE_BITS-1:0]             phase_offset,
  output logic [wstg_pkg::AMP_BITS-1:0]     amplitude,
  output logic [INDEX_BITS:0]               start_index,
  output logic [INDEX_BITS:0]               end_index
);
  import wstg_pkg::*;

  localparam logic [INDEX_BITS:0] END_RESET = (INDEX_BITS+1)'(1) << INDEX_BITS;

  logic wr;

  assign cfg_ready = ~rst;
  assign wr        = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_word    <= PHASE_BITS'(FREQ_WORD_RESET);
      phase_offset <= '0;
      amplitude    <= AMPLITUDE_RESET;
      start_index  <= '0;
      end_index    <= END_RESET;
    end else if (wr) begin
      // drop writes to unknown indexes
      unique case (cfg_index)
        REG_FREQ_WORD:    freq_word    <= cfg_data[PHASE_BITS-1:0];
        REG_PHASE_OFFSET: phase_offset <= cfg_data[PHASE_BITS-1:0];
        REG_AMPLITUDE:    amplitude    <= cfg_data[AMP_BITS-1:0];
        REG_START_INDEX:  start_index  <= cfg_data[INDEX_BITS:0];
        REG_END_INDEX:    end_index    <= cfg_data[INDEX_BITS:0];
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/wstg_phase.sv]
// ----------------------------------------------------------------------------
// wstg_phase
// Window check and phase accumulation: index times increment, then offset,
// folded into a quarter-wave table address.
// ----------------------------------------------------------------------------
module wstg_phase #(
  parameter int INDEX_BITS = wstg_pkg::DEF_INDEX_BITS,
  parameter int PHASE_BITS = wstg_pkg::DEF_PHASE_BITS,
  parameter int TABLE_BITS = wstg_pkg::DEF_TABLE_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [INDEX_BITS-1:0]     sample_index,
  input  logic [PHASE_BITS-1:0]     freq_word,
  input  logic [PHASE_BITS-1:0]     phase_offset,
  input  logic [INDEX_BITS:0]       start_index,
  input  logic [INDEX_BITS:0]       end_index,
  output wstg_pkg::wstg_ctl_t       ctl_out,
  output logic [TABLE_BITS-2:0]     rom_addr
);
  import wstg_pkg::*;

  localparam int ADDR_BITS = TABLE_BITS - 1;
  localparam logic [ADDR_BITS-1:0] QUARTER_LEN = ADDR_BITS'(1) << (TABLE_BITS - 2);

  logic [INDEX_BITS+PHASE_BITS-1:0] prod_full;
  logic [INDEX_BITS:0]              idx_ext;
  logic                             win;
  wstg_ctl_t                        ctl_a;
  logic [PHASE_BITS-1:0]            prod;
  logic [PHASE_BITS-1:0]            phase;
  logic [TABLE_BITS-1:0]            k;
  logic [ADDR_BITS-1:0]             r_ext;

  assign idx_ext   = {1'b0, sample_index};
  assign win       = (idx_ext >= start_index) && (idx_ext < end_index);
  assign prod_full = {{PHASE_BITS{1'b0}}, sample_index} * {{INDEX_BITS{1'b0}}, freq_word};

  // Stage A: multiply
  always_ff @(posedge clk) begin
    if (rst) ctl_a.valid <= 1'b0;
    else     ctl_a.valid <= accept;
    ctl_a.win <= win;
    ctl_a.neg <= 1'b0;
    prod      <= prod_full[PHASE_BITS-1:0];
  end

  assign phase = phase_offset + prod;
  assign k     = phase[PHASE_BITS-1 -: TABLE_BITS];
  assign r_ext = {1'b0, k[TABLE_BITS-3:0]};

  // Stage B: add offset, fold the quadrant onto the quarter table
  always_ff @(posedge clk) begin
    if (rst) ctl_out.valid <= 1'b0;
    else     ctl_out.valid <= ctl_a.valid;
    ctl_out.win <= ctl_a.win;
    ctl_out.neg <= k[TABLE_BITS-1];
    rom_addr    <= k[TABLE_BITS-2] ? (QUARTER_LEN - r_ext) : r_ext;
  end

endmodule

[hw/rtl/wstg_sine_rom.sv]
// ----------------------------------------------------------------------------
// wstg_sine_rom
// Quarter-wave sine table with registered read; contents built at elaboration.
// ----------------------------------------------------------------------------
module wstg_sine_rom #(
  parameter int TABLE_BITS  = wstg_pkg::DEF_TABLE_BITS,
  parameter int SAMPLE_BITS = wstg_pkg::DEF_SAMPLE_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  wstg_pkg::wstg_ctl_t        ctl_in,
  input  logic [TABLE_BITS-2:0]      rom_addr,
  output wstg_pkg::wstg_ctl_t        ctl_out,
  output logic [SAMPLE_BITS-2:0]     mag
);
  import wstg_pkg::*;

  localparam int MAG_BITS    = SAMPLE_BITS - 1;
  localparam int QUARTER_LEN = 1 << (TABLE_BITS - 2);
  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

  typedef logic [MAG_BITS-1:0] rom_t [QUARTER_LEN+1];

  // (a * b) >> 62, low 64 bits
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Truncating quotient by shift and subtract; only used to build the table
  function automatic logic [63:0] div_small(input logic [63:0] a, input logic [63:0] d);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      quo = quo << 1;
      if (rem >= {1'b0, d}) begin
        rem    = rem - {1'b0, d};
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Fixed-point Taylor series of sin(2*pi*q/2^TABLE_BITS), scaled and rounded
  function automatic logic [MAG_BITS-1:0] rom_entry(input int unsigned q);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] n;
    logic [63:0] peak;
    logic [63:0] p_hi;
    logic [63:0] p_lo;
    logic [63:0] acc;
    logic        neg;
    peak = (64'd1 << MAG_BITS) - 64'd1;
    x    = mul_q62(PI_Q62, 64'(q) << (63 - TABLE_BITS));
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    n    = 64'd1;
    neg  = 1'b1;
    while (term != 64'd0) begin
      term = div_small(mul_q62(term, x2), (n + 64'd1) * (n + 64'd2));
      n    = n + 64'd2;
      if (neg) sum = sum - term;
      else     sum = sum + term;
      neg = ~neg;
    end
    p_hi = peak * (sum >> 31);
    p_lo = peak * (sum & 64'h7FFF_FFFF);
    acc  = p_hi + (p_lo >> 31);
    return MAG_BITS'((acc + (64'd1 << 30)) >> 31);
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int q = 0; q <= QUARTER_LEN; q++) begin
      r[q] = rom_entry(q);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Stage C: table read
  always_ff @(posedge clk) begin
    if (rst) ctl_out.valid <= 1'b0;
    else     ctl_out.valid <= ctl_in.valid;
    ctl_out.win <= ctl_in.win;
    ctl_out.neg <= ctl_in.neg;
    mag         <= SINE_ROM[rom_addr];
  end

endmodule

[hw/rtl/wstg_scale.sv]
// ----------------------------------------------------------------------------
// wstg_scale
// Gain stage: magnitude times Q1.15 amplitude, floor shift, clamp, sign and
// window gating into the output registers.
// ----------------------------------------------------------------------------
module wstg_scale #(
  parameter int SAMPLE_BITS = wstg_pkg::DEF_SAMPLE_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  wstg_pkg::wstg_ctl_t              ctl_in,
  input  logic [SAMPLE_BITS-2:0]           mag,
  input  logic [wstg_pkg::AMP_BITS-1:0]    amplitude,
  output logic                             done,
  output logic signed [SAMPLE_BITS-1:0]    sample_value,
  output logic                             in_window
);
  import wstg_pkg::*;

  localparam int MAG_BITS  = SAMPLE_BITS - 1;
  localparam int PROD_BITS = MAG_BITS + AMP_BITS;
  localparam logic [SAMPLE_BITS-1:0] PEAK = {1'b0, {MAG_BITS{1'b1}}};
  localparam logic [PROD_BITS-1:0] ROUND_UP = PROD_BITS'((1 << AMP_FRAC) - 1);

  wstg_ctl_t              ctl_d;
  logic [PROD_BITS-1:0]   prod;
  logic [PROD_BITS-1:0]   rounded;
  logic [SAMPLE_BITS-1:0] quot;
  logic [SAMPLE_BITS-1:0] clamped;
  logic [SAMPLE_BITS-1:0] signed_val;

  // Stage D: multiply
  always_ff @(posedge clk) begin
    if (rst) ctl_d.valid <= 1'b0;
    else     ctl_d.valid <= ctl_in.valid;
    ctl_d.win <= ctl_in.win;
    ctl_d.neg <= ctl_in.neg;
    prod      <= {{AMP_BITS{1'b0}}, mag} * {{MAG_BITS{1'b0}}, amplitude};
  end

  // Negative samples round the magnitude up so the signed shift floors
  assign rounded    = ctl_d.neg ? (prod + ROUND_UP) : prod;
  assign quot       = rounded[PROD_BITS-1:AMP_FRAC];
  assign clamped    = (quot > PEAK) ? PEAK : quot;
  assign signed_val = ctl_d.neg ? (~clamped + SAMPLE_BITS'(1)) : clamped;

  // Stage E: output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= 1'b0;
      in_window <= 1'b0;
    end else begin
      done      <= ctl_d.valid;
      in_window <= ctl_d.valid & ctl_d.win;
    end
    sample_value <= ctl_d.win ? signed_val : '0;
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the windowed sine tone generator core. Sends sample
// index requests with random gaps, works out each tone sample from its own
// phase accumulator, quarter-wave table, gain and window model, and compares
// every done cycle with the oldest sample still owed.
// ----------------------------------------------------------------------------
module tb;
  import wstg_pkg::*;

  localparam int INDEX_BITS  = DEF_INDEX_BITS;
  localparam int PHASE_BITS  = DEF_PHASE_BITS;
  localparam int TABLE_BITS  = DEF_TABLE_BITS;
  localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
  localparam int WIN_BITS    = INDEX_BITS + 1;
  localparam int CFG_BITS    = (PHASE_BITS > INDEX_BITS) ? PHASE_BITS : INDEX_BITS + 1;
  localparam int QUARTER_LEN = 1 << (TABLE_BITS - 2);
  localparam int PEAK        = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int INDEX_SPAN  = 1 << INDEX_BITS;
  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

  localparam int LATENCY        = 5;
  localparam int SETTLE_CYCLES  = 4 * LATENCY;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 16;
  localparam int PHASE_ITEMS    = 50;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          in_window;
  } tone_sample_t;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic [INDEX_BITS-1:0]         sample_index;
  logic                          done;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic                          in_window;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [REG_IDX_BITS-1:0]       cfg_index;
  logic [CFG_BITS-1:0]           cfg_data;

  windowed_sine_tone_generator_core DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample_index (sample_index),
    .done         (done),
    .sample_value (sample_value),
    .in_window    (in_window),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Tone settings as the block should hold them
  logic [PHASE_BITS-1:0] step_word;
  logic [PHASE_BITS-1:0] phase_base;
  logic [AMP_BITS-1:0]   gain;
  logic [WIN_BITS-1:0]   win_start;
  logic [WIN_BITS-1:0]   win_end;

  int           sine_quarter [0:QUARTER_LEN];
  tone_sample_t owed_samples [$];
  int           results_owed;
  int           errors;
  int           requests_taken;
  int           samples_checked;
  int           window_hits;
  int           clipped_hits;
  int           reg_writes;
  int           quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // (a * b) >> 62 over the full 128-bit product
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // Quarter-wave entry by Taylor series in Q62, rounded half away from zero
  function automatic int quarter_sine(input int q);
    logic [63:0] x, x2, term, sum, n, p_hi, p_lo, acc;
    bit          neg;
    x    = mul_q62(PI_Q62, 64'(q) << (63 - TABLE_BITS));
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    n    = 64'd1;
    neg  = 1'b1;
    while (term != 64'd0) begin
      term = mul_q62(term, x2) / ((n + 64'd1) * (n + 64'd2));
      n    = n + 64'd2;
      if (neg) sum = sum - term;
      else sum = sum + term;
      neg = !neg;
    end
    p_hi = 64'(PEAK) * (sum >> 31);
    p_lo = 64'(PEAK) * (sum & 64'h7FFF_FFFF);
    acc  = p_hi + (p_lo >> 31);
    return int'((acc + (64'd1 << 30)) >> 31);
  endfunction

  function automatic tone_sample_t predict_tone(input logic [INDEX_BITS-1:0] idx);
    tone_sample_t          res;
    logic [PHASE_BITS-1:0] phase;
    logic [TABLE_BITS-1:0] addr;
    int                    mag;
    longint                scaled;
    res.value     = '0;
    res.in_window = 1'b0;
    if ({1'b0, idx} >= win_start && {1'b0, idx} < win_end) begin
      phase = phase_base + idx * step_word;
      addr  = phase[PHASE_BITS-1 -: TABLE_BITS];
      // fold into the first quarter, mirror on odd quadrants, negate the back half
      if (addr[TABLE_BITS-2]) mag = sine_quarter[QUARTER_LEN - int'(addr[TABLE_BITS-3:0])];
      else mag = sine_quarter[addr[TABLE_BITS-3:0]];
      if (addr[TABLE_BITS-1]) mag = -mag;
      scaled = (longint'(mag) * longint'(gain)) >>> AMP_FRAC;
      if (scaled > PEAK) scaled = PEAK;
      if (scaled < -PEAK) scaled = -PEAK;
      res.value     = scaled[SAMPLE_BITS-1:0];
      res.in_window = 1'b1;
    end
    return res;
  endfunction

  // Track settings, predict each request and check each result
  always @(posedge clk) begin
    tone_sample_t want;
    if (rst) begin
      step_word  = FREQ_WORD_RESET[PHASE_BITS-1:0];
      phase_base = '0;
      gain       = AMPLITUDE_RESET;
      win_start  = '0;
      win_end    = WIN_BITS'(INDEX_SPAN);
      owed_samples.delete();
      results_owed <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          REG_FREQ_WORD:    step_word  = cfg_data[PHASE_BITS-1:0];
          REG_PHASE_OFFSET: phase_base = cfg_data[PHASE_BITS-1:0];
          REG_AMPLITUDE:    gain       = cfg_data[AMP_BITS-1:0];
          REG_START_INDEX:  win_start  = cfg_data[WIN_BITS-1:0];
          REG_END_INDEX:    win_end    = cfg_data[WIN_BITS-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        owed_samples.push_back(predict_tone(sample_index));
        requests_taken++;
      end
      if (done) begin
        if (owed_samples.size() == 0) begin
          errors++;
          $error("result with no request waiting: sample_value %0d in_window %0b",
                 sample_value, in_window);
        end else begin
          want = owed_samples.pop_front();
          samples_checked++;
          if (want.in_window) window_hits++;
          if (want.in_window && (want.value == PEAK || want.value == -PEAK)) clipped_hits++;
          if (sample_value !== want.value) begin
            errors++;
            $error("sample_value: expected %0d, got %0d", want.value, sample_value);
          end
          if (in_window !== want.in_window) begin
            errors++;
            $error("in_window: expected %0b, got %0b", want.in_window, in_window);
          end
        end
      end
      results_owed <= owed_samples.size();
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || (cfg_valid && cfg_ready) || done) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_sample(input logic [INDEX_BITS-1:0] idx, input bit gapless = 1'b0);
    int gap;
    start        <= 1'b1;
    sample_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = gapless ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off requests until every owed sample has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  task automatic write_reg(input logic [REG_IDX_BITS-1:0] code, input logic [CFG_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= code;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_values();
    send_sample('0);
    send_sample('1);
    send_sample(INDEX_BITS'(3));
  endtask

  task automatic test_quadrants();
    drain_results();
    write_reg(REG_FREQ_WORD, CFG_BITS'(1) << (PHASE_BITS - TABLE_BITS));
    write_reg(REG_PHASE_OFFSET, '0);
    write_reg(REG_AMPLITUDE, CFG_BITS'(1) << AMP_FRAC);
    send_sample(INDEX_BITS'(0));
    send_sample(INDEX_BITS'(QUARTER_LEN - 1));
    send_sample(INDEX_BITS'(QUARTER_LEN));
    send_sample(INDEX_BITS'(2 * QUARTER_LEN));
    send_sample(INDEX_BITS'(3 * QUARTER_LEN));
    send_sample(INDEX_BITS'(4 * QUARTER_LEN - 1));
  endtask

  task automatic test_gain_limits();
    drain_results();
    // all ones: gain above full scale, upper data bits dropped
    write_reg(REG_AMPLITUDE, '1);
    send_sample(INDEX_BITS'(QUARTER_LEN));
    send_sample(INDEX_BITS'(3 * QUARTER_LEN));
    drain_results();
    write_reg(REG_AMPLITUDE, '0);
    send_sample(INDEX_BITS'(QUARTER_LEN));
    drain_results();
    write_reg(REG_AMPLITUDE, {{(CFG_BITS - AMP_BITS){1'b1}}, AMP_BITS'(1 << AMP_FRAC)});
    send_sample(INDEX_BITS'(3 * QUARTER_LEN));
  endtask

  task automatic test_window_edges();
    drain_results();
    write_reg(REG_START_INDEX, {{(CFG_BITS - WIN_BITS){1'b1}}, WIN_BITS'(100)});
    write_reg(REG_END_INDEX, {{(CFG_BITS - WIN_BITS){1'b1}}, WIN_BITS'(200)});
    send_sample(INDEX_BITS'(99));
    send_sample(INDEX_BITS'(100));
    send_sample(INDEX_BITS'(199));
    send_sample(INDEX_BITS'(200));
    drain_results();
    // start equal to end: empty window
    write_reg(REG_START_INDEX, CFG_BITS'(50));
    write_reg(REG_END_INDEX, CFG_BITS'(50));
    send_sample(INDEX_BITS'(50));
    drain_results();
    // start above end: empty window
    write_reg(REG_START_INDEX, CFG_BITS'(INDEX_SPAN));
    write_reg(REG_END_INDEX, '0);
    send_sample('0);
    send_sample('1);
  endtask

  task automatic test_unknown_registers();
    logic [REG_IDX_BITS-1:0] code;
    drain_results();
    write_reg(REG_START_INDEX, '0);
    write_reg(REG_END_INDEX, CFG_BITS'(INDEX_SPAN));
    for (int i = int'(REG_END_INDEX) + 1; i < (1 << REG_IDX_BITS); i++) begin
      code = REG_IDX_BITS'(i);
      write_reg(code, '1);
    end
    send_sample(INDEX_BITS'(QUARTER_LEN));
  endtask

  task automatic test_phase_wrap();
    drain_results();
    write_reg(REG_FREQ_WORD, '1);
    write_reg(REG_PHASE_OFFSET, '1);
    send_sample('0);
    send_sample('1);
  endtask

  task automatic test_random_phase(input int n_items, input bit gapless);
    logic [CFG_BITS-1:0]   freq;
    logic [AMP_BITS-1:0]   amp;
    logic [WIN_BITS-1:0]   lo, hi, top;
    logic [INDEX_BITS-1:0] idx;
    logic [REG_IDX_BITS-1:0] code;
    int                    pick;
    drain_results();
    pick = $urandom_range(0, 7);
    if (pick == 0) freq = '0;
    else if (pick == 1) freq = '1;
    else if (pick == 2) freq = CFG_BITS'(1) << $urandom_range(0, PHASE_BITS - 1);
    else freq = CFG_BITS'($urandom);
    write_reg(REG_FREQ_WORD, freq);
    write_reg(REG_PHASE_OFFSET, CFG_BITS'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 70) amp = AMP_BITS'($urandom_range(0, 1 << AMP_FRAC));
    else if (pick < 85) amp = AMP_BITS'(1 << AMP_FRAC);
    else amp = AMP_BITS'($urandom_range((1 << AMP_FRAC) + 1, (1 << AMP_BITS) - 1));
    write_reg(REG_AMPLITUDE, {(CFG_BITS - AMP_BITS)'($urandom), amp});
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      lo = '0;
      hi = WIN_BITS'(INDEX_SPAN);
    end else if (pick == 1) begin
      hi = WIN_BITS'($urandom_range(0, INDEX_SPAN));
      lo = WIN_BITS'($urandom_range(hi, INDEX_SPAN));
    end else if (pick < 6) begin
      lo = WIN_BITS'($urandom_range(0, INDEX_SPAN - 1));
      hi = WIN_BITS'($urandom_range(lo + 1, INDEX_SPAN));
    end else begin
      lo = WIN_BITS'($urandom_range(0, INDEX_SPAN - 1));
      hi = lo + WIN_BITS'($urandom_range(1, 4096));
      if (hi > INDEX_SPAN) hi = WIN_BITS'(INDEX_SPAN);
    end
    write_reg(REG_START_INDEX, {(CFG_BITS - WIN_BITS)'($urandom), lo});
    write_reg(REG_END_INDEX, {(CFG_BITS - WIN_BITS)'($urandom), hi});
    if ($urandom_range(0, 3) == 0) begin
      code = REG_IDX_BITS'($urandom_range(int'(REG_END_INDEX) + 1, (1 << REG_IDX_BITS) - 1));
      write_reg(code, CFG_BITS'($urandom));
    end
    top = hi;
    if (top > INDEX_SPAN) top = WIN_BITS'(INDEX_SPAN);
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6 && lo < top) begin
        idx = INDEX_BITS'($urandom_range(lo, top - 1));
      end else if (pick < 8) begin
        case ($urandom_range(0, 3))
          0: idx = INDEX_BITS'(lo - 1);
          1: idx = INDEX_BITS'(lo);
          2: idx = INDEX_BITS'(hi - 1);
          default: idx = INDEX_BITS'(hi);
        endcase
      end else begin
        idx = INDEX_BITS'($urandom);
      end
      send_sample(idx, gapless);
    end
  endtask

  initial begin
    errors          = 0;
    requests_taken  = 0;
    samples_checked = 0;
    window_hits     = 0;
    clipped_hits    = 0;
    reg_writes      = 0;
    quiet_cycles    = 0;
    rst          <= 1'b1;
    start        <= 1'b0;
    sample_index <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_FREQ_WORD;
    cfg_data     <= '0;
    for (int q = 0; q <= QUARTER_LEN; q++) sine_quarter[q] = quarter_sine(q);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_quadrants();
    test_gain_limits();
    test_window_edges();
    test_unknown_registers();
    test_phase_wrap();
    for (int p = 0; p < RANDOM_PHASES; p++) test_random_phase(PHASE_ITEMS, (p % 4) == 0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (owed_samples.size() != 0) begin
      errors++;
      $error("%0d samples never came back", owed_samples.size());
    end
    $display("Checked %0d tone samples from %0d requests over %0d register writes.",
             samples_checked, requests_taken, reg_writes);
    $display("%0d samples fell inside the window, %0d of them at full-scale clip.",
             window_hits, clipped_hits);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
